>>> rtl/pwrac_pkg.sv
// Shared types and constants for the paged word rotate-add checksum.
// Used by every module of the block; depends on nothing else.

package pwrac_pkg;

   // Payload and register widths
   localparam int DATA_W  = 64;
   localparam int ADDR_W  = 64;
   localparam int LEN_W   = 32;
   localparam int TOTAL_W = 30;

   // Address bits that hold the word count of a range (mod 2^TOTAL_W words)
   localparam int SPAN_W = TOTAL_W + 3;

   // Page geometry and word grouping
   localparam int PAGE_BYTES_DEFAULT = 4096;
   localparam int WORD_BYTES         = 8;
   localparam int GROUP_WORDS        = 4;
   localparam logic [1:0] LAST_GROUP_POS = 2'd3;

   // Queue depths
   localparam int MID_DEPTH = 4;
   localparam int OUT_DEPTH = 2;

   // Configuration port
   localparam int CSR_INDEX_W = 4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BASE_ADDRESS = 4'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BYTE_LENGTH  = 4'd1;

   // Arming sequencer
   typedef enum logic [2:0] {
      ARM_SPAN  = 3'b001,
      ARM_LOAD  = 3'b010,
      ARM_READY = 3'b100
   } arm_state_type;

   // One classified word on its way from the front end to the back end
   typedef struct packed {
      logic [DATA_W-1:0] word;
      logic              xor_after;
      logic              chunk_end;
      logic              last;
   } item_type;

endpackage

>>> rtl/pwrac_fifo.sv
// Small first-in first-out queue with registered storage and counters.
// Generic; takes its default parameters from pwrac_pkg.

module pwrac_fifo #(
   parameter int WIDTH = pwrac_pkg::DATA_W,
   parameter int DEPTH = pwrac_pkg::MID_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> rtl/pwrac_front.sv
// Front end: configuration registers, range arming and per-word classification.
// Uses pwrac_pkg for widths, register indexes, the arming states and item_type.

module pwrac_front #(
   parameter int PAGE_BYTES = pwrac_pkg::PAGE_BYTES_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // configuration
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pwrac_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [pwrac_pkg::ADDR_W-1:0]        csr_data,
   // incoming words
   input  logic                                req_push,
   output logic                                req_full,
   input  logic [pwrac_pkg::DATA_W-1:0]        req_data_word,
   // toward the middle queue and back end
   output logic                                mid_push,
   output pwrac_pkg::item_type                 mid_item,
   input  logic                                mid_full,
   output logic                                flush
);

   localparam int PAGE_WORDS = PAGE_BYTES / pwrac_pkg::WORD_BYTES;
   localparam int CHUNK_W    = $clog2(PAGE_WORDS + 1);
   localparam int OFF_W      = $clog2(PAGE_BYTES);
   localparam int REM_W      = OFF_W + 1;
   localparam int TOTAL_W    = pwrac_pkg::TOTAL_W;
   localparam int SPAN_W     = pwrac_pkg::SPAN_W;
   localparam int ADDR_W     = pwrac_pkg::ADDR_W;
   localparam int LEN_W      = pwrac_pkg::LEN_W;

   pwrac_pkg::arm_state_type state_ff, state_in;

   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [LEN_W-1:0]   len_ff, len_in;
   logic [SPAN_W-1:0]  end_ff, end_in;
   logic [TOTAL_W-1:0] arm_total_ff, arm_total_in;
   logic [CHUNK_W-1:0] arm_chunk_ff, arm_chunk_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [CHUNK_W-1:0] chunk_ff, chunk_in;
   logic [1:0]         group_pos_ff, group_pos_in;

   logic               csr_write;
   logic               known_index;
   logic               accept;
   logic               tail;
   logic [ADDR_W-1:0]  first_addr;
   logic [LEN_W-1:0]   len_eff;
   logic [OFF_W-1:0]   page_off;
   logic [REM_W-1:0]   chunk_bytes;
   logic [CHUNK_W-1:0] chunk_first;
   logic [TOTAL_W-1:0] total_calc;

   assign csr_ready   = 1'b1;
   assign csr_write   = csr_valid && csr_ready;
   assign known_index = (csr_index == pwrac_pkg::CSR_BASE_ADDRESS) ||
                        (csr_index == pwrac_pkg::CSR_BYTE_LENGTH);
   assign flush       = csr_write && known_index;

   assign req_full = (state_ff != pwrac_pkg::ARM_READY) || mid_full;
   assign accept   = req_push && !req_full;
   assign mid_push = accept;

   assign first_addr = {base_ff[ADDR_W-1:3], 3'b000};
   assign len_eff    = (len_ff == '0) ? LEN_W'(1) : len_ff;

   // Page offset of the first word; pages are a power of two in size
   assign page_off = first_addr[OFF_W-1:0];

   // First chunk length and range word count from the finished arithmetic
   assign chunk_bytes = REM_W'(PAGE_BYTES) - {1'b0, page_off};
   assign total_calc  = end_ff[SPAN_W-1:3] - first_addr[SPAN_W-1:3] + 1'b1;

   always_comb begin
      chunk_first = CHUNK_W'(chunk_bytes >> 3);
      if (chunk_first == '0) begin
         chunk_first = CHUNK_W'(PAGE_WORDS);
      end
   end

   // Classify the word being accepted
   assign tail = (group_pos_ff == 2'd0) &&
                 ((chunk_ff < CHUNK_W'(pwrac_pkg::GROUP_WORDS)) ||
                  (total_ff < TOTAL_W'(pwrac_pkg::GROUP_WORDS)));

   always_comb begin
      mid_item.word      = req_data_word;
      mid_item.xor_after = tail || (group_pos_ff == pwrac_pkg::LAST_GROUP_POS);
      mid_item.chunk_end = (chunk_ff == CHUNK_W'(1)) || (total_ff == TOTAL_W'(1));
      mid_item.last      = (total_ff == TOTAL_W'(1));
   end

   // Register writes, arming sequence and chunk counters
   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      len_in       = len_ff;
      end_in       = end_ff;
      arm_total_in = arm_total_ff;
      arm_chunk_in = arm_chunk_ff;
      total_in     = total_ff;
      chunk_in     = chunk_ff;
      group_pos_in = group_pos_ff;

      if (csr_write) begin
         if (csr_index == pwrac_pkg::CSR_BASE_ADDRESS) begin
            base_in = csr_data;
         end else if (csr_index == pwrac_pkg::CSR_BYTE_LENGTH) begin
            len_in = csr_data[LEN_W-1:0];
         end
      end

      if (flush) begin
         state_in = pwrac_pkg::ARM_SPAN;
      end else begin
         unique case (state_ff)
            pwrac_pkg::ARM_SPAN: begin
               end_in   = base_ff[SPAN_W-1:0] + SPAN_W'(len_eff) - 1'b1;
               state_in = pwrac_pkg::ARM_LOAD;
            end
            pwrac_pkg::ARM_LOAD: begin
               arm_total_in = (total_calc == '0) ? TOTAL_W'(1) : total_calc;
               arm_chunk_in = chunk_first;
               total_in     = (total_calc == '0) ? TOTAL_W'(1) : total_calc;
               chunk_in     = chunk_first;
               group_pos_in = 2'd0;
               state_in     = pwrac_pkg::ARM_READY;
            end
            pwrac_pkg::ARM_READY: begin
               if (accept) begin
                  if (mid_item.last) begin
                     // re-arm for the next pass over the same range
                     total_in     = arm_total_ff;
                     chunk_in     = arm_chunk_ff;
                     group_pos_in = 2'd0;
                  end else if (mid_item.chunk_end) begin
                     total_in     = total_ff - 1'b1;
                     chunk_in     = CHUNK_W'(PAGE_WORDS);
                     group_pos_in = 2'd0;
                  end else begin
                     total_in     = total_ff - 1'b1;
                     chunk_in     = chunk_ff - 1'b1;
                     group_pos_in = tail ? 2'd0 : group_pos_ff + 1'b1;
                  end
               end
            end
            default: state_in = pwrac_pkg::ARM_SPAN;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pwrac_pkg::ARM_SPAN;
         base_ff      <= '0;
         len_ff       <= LEN_W'(1);
         total_ff     <= '0;
         chunk_ff     <= '0;
         group_pos_ff <= '0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         len_ff       <= len_in;
         total_ff     <= total_in;
         chunk_ff     <= chunk_in;
         group_pos_ff <= group_pos_in;
      end
   end

   // Hold arming arithmetic
   always_ff @(posedge clock) begin
      end_ff       <= end_in;
      arm_total_ff <= arm_total_in;
      arm_chunk_ff <= arm_chunk_in;
   end

endmodule

>>> rtl/pwrac_back.sv
// Back end: rotate and add sums per chunk, then fold chunk sums into the total.
// Uses pwrac_pkg for item_type and the data width.

module pwrac_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          flush,
   // from the middle queue
   input  logic                          mid_empty,
   input  pwrac_pkg::item_type           mid_item,
   output logic                          mid_pop,
   // toward the result queue
   input  logic                          out_full,
   output logic                          out_push,
   output logic [pwrac_pkg::DATA_W-1:0]  out_data
);

   localparam int DATA_W = pwrac_pkg::DATA_W;

   logic [DATA_W-1:0] rot_sum_ff, rot_sum_in;
   logic [DATA_W-1:0] add_sum_ff, add_sum_in;
   logic [DATA_W-1:0] pend_rot_ff, pend_rot_in;
   logic [DATA_W-1:0] pend_add_ff, pend_add_in;
   logic              pend_valid_ff, pend_valid_in;
   logic              pend_last_ff, pend_last_in;
   logic [DATA_W-1:0] run_xor_ff, run_xor_in;

   logic              fold_go;
   logic              sum_go;
   logic [DATA_W-1:0] mixed;
   logic [DATA_W-1:0] rot_next;
   logic [DATA_W-1:0] add_next;
   logic [DATA_W-1:0] rot_final;
   logic [DATA_W-1:0] chunk_sum;
   logic [DATA_W-1:0] fold_value;

   // Fold stage moves unless a final result waits on a full result queue
   assign fold_go = !(pend_valid_ff && pend_last_ff && out_full);
   assign sum_go  = !mid_empty && fold_go;
   assign mid_pop = sum_go;

   // Sum stage: rotate right by one (left by 63) and add
   assign mixed     = rot_sum_ff ^ mid_item.word;
   assign rot_next  = {mixed[0], mixed[DATA_W-1:1]};
   assign add_next  = add_sum_ff + mid_item.word;
   assign rot_final = mid_item.xor_after ? (rot_next ^ add_next) : rot_next;

   // Fold stage: chunk checksum into the running XOR
   assign chunk_sum  = pend_rot_ff + pend_add_ff;
   assign fold_value = run_xor_ff ^ chunk_sum;
   assign out_push   = pend_valid_ff && pend_last_ff && fold_go;
   assign out_data   = fold_value;

   always_comb begin
      rot_sum_in    = rot_sum_ff;
      add_sum_in    = add_sum_ff;
      pend_rot_in   = pend_rot_ff;
      pend_add_in   = pend_add_ff;
      pend_last_in  = pend_last_ff;
      pend_valid_in = pend_valid_ff && !fold_go;
      run_xor_in    = run_xor_ff;

      if (pend_valid_ff && fold_go) begin
         run_xor_in = pend_last_ff ? '0 : fold_value;
      end

      if (sum_go) begin
         if (mid_item.chunk_end) begin
            pend_rot_in   = rot_final;
            pend_add_in   = add_next;
            pend_last_in  = mid_item.last;
            pend_valid_in = 1'b1;
            rot_sum_in    = '0;
            add_sum_in    = '0;
         end else begin
            rot_sum_in = rot_final;
            add_sum_in = add_next;
         end
      end

      // Drop any partial checksum on a register write
      if (flush) begin
         rot_sum_in    = '0;
         add_sum_in    = '0;
         run_xor_in    = '0;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rot_sum_ff    <= '0;
         add_sum_ff    <= '0;
         run_xor_ff    <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         rot_sum_ff    <= rot_sum_in;
         add_sum_ff    <= add_sum_in;
         run_xor_ff    <= run_xor_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // Hold the finished chunk for the fold stage
   always_ff @(posedge clock) begin
      pend_rot_ff  <= pend_rot_in;
      pend_add_ff  <= pend_add_in;
      pend_last_ff <= pend_last_in;
   end

endmodule

>>> rtl/paged_word_rotate_add_checksum.sv
// Top level of the paged word rotate-add checksum.
// Instantiates pwrac_front, pwrac_back and two pwrac_fifo queues; uses pwrac_pkg.

// Checksums the aligned 64-bit words of the byte range set by base_address
// (register 0) and byte_length (register 1). Push the words in address order;
// after the last word of the range one checksum appears on the result side and
// the block re-arms for another pass over the same range. It takes one word
// per clock cycle while req_full is low, limited by the single 64-bit add of
// the sum stage. After reset and after every write to either register the
// front end arms the range through ARM_SPAN, which finds the end address, and
// ARM_LOAD, which loads the counters, and holds req_full high meanwhile.
// PAGE_BYTES must be a power of two from 64 to 65536. A word reaches the back
// end through a four-entry queue; a checksum passes the pending registers of
// the fold stage and the result queue on its way out, and a two-entry result
// queue lets words keep flowing while an earlier result waits to be popped.

module paged_word_rotate_add_checksum #(
   parameter int PAGE_BYTES = pwrac_pkg::PAGE_BYTES_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   // configuration
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [pwrac_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [pwrac_pkg::ADDR_W-1:0]       csr_data,
   // words in
   input  logic                               req_push,
   output logic                               req_full,
   input  logic [pwrac_pkg::DATA_W-1:0]       req_data_word,
   // checksums out
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output logic [pwrac_pkg::DATA_W-1:0]       rsp_checksum_value
);

   localparam int ITEM_W = $bits(pwrac_pkg::item_type);

   logic                          mid_push;
   logic                          mid_full;
   logic                          mid_empty;
   logic                          mid_pop;
   logic                          flush;
   pwrac_pkg::item_type           front_item;
   pwrac_pkg::item_type           back_item;
   logic [ITEM_W-1:0]             back_item_bits;
   logic                          out_push;
   logic                          out_full;
   logic [pwrac_pkg::DATA_W-1:0]  out_data;

   assign back_item = pwrac_pkg::item_type'(back_item_bits);

   // Accept and classify words
   pwrac_front #(
      .PAGE_BYTES (PAGE_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .req_push      (req_push),
      .req_full      (req_full),
      .req_data_word (req_data_word),
      .mid_push      (mid_push),
      .mid_item      (front_item),
      .mid_full      (mid_full),
      .flush         (flush)
   );

   // Decouple front and back
   pwrac_fifo #(
      .WIDTH (ITEM_W),
      .DEPTH (pwrac_pkg::MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (mid_push),
      .push_data (ITEM_W'(front_item)),
      .full      (mid_full),
      .pop       (mid_pop),
      .pop_data  (back_item_bits),
      .empty     (mid_empty)
   );

   // Run the sums and fold chunk checksums
   pwrac_back u_back (
      .clock     (clock),
      .reset     (reset),
      .flush     (flush),
      .mid_empty (mid_empty),
      .mid_item  (back_item),
      .mid_pop   (mid_pop),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_data  (out_data)
   );

   // Hold finished checksums until popped
   pwrac_fifo #(
      .WIDTH (pwrac_pkg::DATA_W),
      .DEPTH (pwrac_pkg::OUT_DEPTH)
   ) u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_checksum_value),
      .empty     (rsp_empty)
   );

endmodule
